[design/npm_pkg.sv]
`default_nettype none

package npm_pkg;

	// coordinate and result field widths
	localparam int COORD_BITS      = 16;
	localparam int IDX_W           = 10;
	localparam int DIST_W          = 2 * COORD_BITS + 1;
	localparam int MAX_TARGETS_DEF = 1024;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} coord_pair_t;

	typedef struct packed {
		op_t                          op;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  match_index;
		logic              found;
		logic [DIST_W-1:0] dist_sqrd;
	} out_item_t;

endpackage

`default_nettype wire

[design/npm_store.sv]
`default_nettype none

module npm_store import npm_pkg::*; #(
	parameter int MAX_TARGETS = MAX_TARGETS_DEF,
	localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1
) (
	input  wire                clk,
	input  wire                we,
	input  wire [AW-1:0]       waddr,
	input  coord_pair_t        wdata,
	input  wire                re,
	input  wire [AW-1:0]       raddr,
	output coord_pair_t        rdata
);

	coord_pair_t mem_q [MAX_TARGETS];

	// single write port for loads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read for the scan
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/npm_dist.sv]
`default_nettype none

module npm_dist import npm_pkg::*; #(
	parameter int MAX_TARGETS = MAX_TARGETS_DEF,
	localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                valid_s1,
	input  wire [AW-1:0]       idx_s1,
	input  coord_pair_t        target_s1,
	input  coord_pair_t        qpt,
	output logic               valid_s2,
	output logic [AW-1:0]      idx_s2,
	output logic [DIST_W-1:0]  dist_s2
);

	localparam int SQ_W = 2 * COORD_BITS;

	logic [COORD_BITS:0]   dx, dy, ndx, ndy;
	logic [COORD_BITS-1:0] mag_x, mag_y;
	logic [SQ_W-1:0]       sqx_s2, sqy_s2;

	// absolute differences, one extra bit so nothing wraps
	always_comb begin
		dx    = {qpt.x[COORD_BITS-1], qpt.x} - {target_s1.x[COORD_BITS-1], target_s1.x};
		dy    = {qpt.y[COORD_BITS-1], qpt.y} - {target_s1.y[COORD_BITS-1], target_s1.y};
		ndx   = ~dx + 1'b1;
		ndy   = ~dy + 1'b1;
		mag_x = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
		mag_y = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
	end

	// squares registered
	always_ff @(posedge clk) begin
		sqx_s2 <= mag_x * mag_x;
		sqy_s2 <= mag_y * mag_y;
		idx_s2 <= idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// sum feeds the compare in the sequencer
	assign dist_s2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};

endmodule

`default_nettype wire

[design/npm_ctrl.sv]
`default_nettype none

module npm_ctrl import npm_pkg::*; #(
	parameter int MAX_TARGETS = MAX_TARGETS_DEF,
	localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  in_item_t           in_data,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output coord_pair_t        mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	output logic               valid_s1,
	output logic [AW-1:0]      idx_s1,
	output coord_pair_t        qpt,
	input  wire                dist_valid,
	input  wire [AW-1:0]       dist_idx,
	input  wire [DIST_W-1:0]   dist_val,
	input  wire                out_free,
	output logic               res_load,
	output out_item_t          res_data
);

	localparam int CW = $clog2(MAX_TARGETS + 1);

	state_t              state_q, state_d;
	logic [CW-1:0]       count_q, scan_q, scan_nxt;
	logic                acc, full, issue, last;
	logic                have_q, upd;
	logic [DIST_W-1:0]   best_q;
	logic [AW-1:0]       best_idx_q;
	logic [IDX_W+AW-1:0] idx_ext;

	assign acc      = in_valid && in_ready;
	assign full     = (count_q == CW'(MAX_TARGETS));
	assign scan_nxt = scan_q + 1'b1;
	assign last     = (scan_nxt == count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && in_data.op == OP_QUERY) begin
					state_d = (count_q == '0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!valid_s1 && !dist_valid) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		res_load = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_SCAN:  issue    = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  res_load = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			valid_s1 <= 1'b0;
			have_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (acc) begin
				case (in_data.op)
					OP_CLEAR: count_q <= '0;
					OP_LOAD: begin
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
					end
					OP_QUERY: have_q <= 1'b0;
					default: ;
				endcase
			end
			if (upd) begin
				have_q <= 1'b1;
			end
		end
	end

	// query point, scan position and running best
	always_ff @(posedge clk) begin
		if (acc && in_data.op == OP_QUERY) begin
			qpt.x  <= in_data.point_x;
			qpt.y  <= in_data.point_y;
			scan_q <= '0;
		end else if (issue) begin
			scan_q <= scan_nxt;
		end
		idx_s1 <= scan_q[AW-1:0];
		if (upd) begin
			best_q     <= dist_val;
			best_idx_q <= dist_idx;
		end
	end

	// strict less-than keeps the lower index on ties
	assign upd = dist_valid && (!have_q || dist_val < best_q);

	// target store access
	assign mem_we          = acc && in_data.op == OP_LOAD && !full;
	assign mem_waddr       = count_q[AW-1:0];
	assign mem_wdata.x     = in_data.point_x;
	assign mem_wdata.y     = in_data.point_y;
	assign mem_re          = issue;
	assign mem_raddr       = scan_q[AW-1:0];

	// result, zeroed for an empty set
	assign idx_ext              = {{IDX_W{1'b0}}, best_idx_q};
	assign res_data.match_index = have_q ? idx_ext[IDX_W-1:0] : '0;
	assign res_data.found       = have_q;
	assign res_data.dist_sqrd   = have_q ? best_q : '0;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TARGETS))
		else $error("target count beyond capacity");

	a_scan_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> scan_q < count_q)
		else $error("scan reads past stored targets");

	a_no_stray_dist: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("distance in flight outside a query");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !valid_s1 && !dist_valid)
		else $error("result taken before the pipe drained");

endmodule

`default_nettype wire

[design/nearest_point_match_2d_top.sv]
// Brute-force 2D nearest-neighbour match over a stored target set.
// Input channel (in_valid/in_ready/in_data) takes one item: op clear empties
// the set, op load appends a Q6.10 point (dropped when the set is full), op
// query searches the set for the point nearest to the given one; op code 3 is
// ignored. Only a query gives a result, on out_valid/out_ready/out_data:
// index of the first closest target, found flag and squared distance (Q13.20).
// Clear and load leave in_ready high; the next item is taken the cycle after.
// A query over N stored targets reads one target per cycle from the read port
// of the target memory through one distance datapath (subtract, square, add
// and compare), waits for that datapath to drain and then registers its result
// (an empty set skips the scan); in_ready stays low until the result is loaded.
// The result sits in an output register; loads and clears are still taken
// while it waits. If a further query finishes while the receiver still
// stalls, it holds until the output register frees.
// Reset empties the target set and clears the handshake state; the stored
// coordinates themselves are not cleared.
`default_nettype none

module nearest_point_match_2d_top import npm_pkg::*; #(
	parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  wire         out_ready,
	output out_item_t   out_data
);

	localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

	logic              mem_we, mem_re, valid_s1, valid_s2, res_load, out_free;
	logic [AW-1:0]     mem_waddr, mem_raddr, idx_s1, idx_s2;
	coord_pair_t       mem_wdata, rdata, qpt;
	logic [DIST_W-1:0] dist_s2;
	out_item_t         res_data;

	npm_ctrl #(.MAX_TARGETS(MAX_TARGETS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.valid_s1   (valid_s1),
		.idx_s1     (idx_s1),
		.qpt        (qpt),
		.dist_valid (valid_s2),
		.dist_idx   (idx_s2),
		.dist_val   (dist_s2),
		.out_free   (out_free),
		.res_load   (res_load),
		.res_data   (res_data)
	);

	npm_store #(.MAX_TARGETS(MAX_TARGETS)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	npm_dist #(.MAX_TARGETS(MAX_TARGETS)) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.idx_s1    (idx_s1),
		.target_s1 (rdata),
		.qpt       (qpt),
		.valid_s2  (valid_s2),
		.idx_s2    (idx_s2),
		.dist_s2   (dist_s2)
	);

	// output register
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_data <= res_data;
		end
	end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import npm_pkg::*;

	localparam int         MAX_TGT    = MAX_TARGETS_DEF;
	localparam int         IDLE_LIMIT = 5000;
	localparam int         REPORT_CAP = 100;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// shadow copy of the target set
	logic signed [COORD_BITS-1:0] target_x [MAX_TGT];
	logic signed [COORD_BITS-1:0] target_y [MAX_TGT];
	int target_count = 0;

	out_item_t expected_matches [$];

	int n_errors      = 0;
	int n_items       = 0;
	int n_results     = 0;
	bit sender_bursty = 1'b1;
	int burst_left    = 0;
	int hold_left     = 0;
	int idle_cycles   = 0;

	nearest_point_match_2d_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (n_errors < REPORT_CAP)
			$display("tb: mismatch at result %0d: %s", n_results, msg);
		n_errors++;
	endtask

	// exhaustive scan in index order, strict less-than keeps the first minimum
	function automatic out_item_t nearest_target(input logic signed [COORD_BITS-1:0] qx,
			input logic signed [COORD_BITS-1:0] qy);
		out_item_t best;
		longint    dx;
		longint    dy;
		longint    d;
		longint    best_d;
		best = '0;
		best_d = 0;
		for (int i = 0; i < target_count; i++) begin
			dx = longint'(qx) - longint'(target_x[i]);
			dy = longint'(qy) - longint'(target_y[i]);
			d = dx * dx + dy * dy;
			if (!best.found || d < best_d) begin
				best_d = d;
				best.match_index = IDX_W'(i);
				best.found = 1'b1;
			end
		end
		best.dist_sqrd = DIST_W'(best_d);
		return best;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] rand_coord();
		int sel;
		int v;
		sel = $urandom_range(0, 9);
		case (sel)
			0: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2, 3: begin
				// dense cluster, plenty of ties
				v = int'($urandom_range(0, 127)) - 64;
				return COORD_BITS'(v);
			end
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	// one item on the input channel; shadow state follows at acceptance
	task automatic send_item(input op_t op, input logic signed [COORD_BITS-1:0] x,
			input logic signed [COORD_BITS-1:0] y);
		in_item_t it;
		int       gap;
		it.op = op;
		it.point_x = x;
		it.point_y = y;
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		case (op)
			OP_CLEAR: target_count = 0;
			OP_LOAD: begin
				if (target_count < MAX_TGT) begin
					target_x[target_count] = x;
					target_y[target_count] = y;
					target_count++;
				end
			end
			OP_QUERY: expected_matches.insert(expected_matches.size(), nearest_target(x, y));
			default: ;
		endcase
		if (op != op_t'(OP_UNUSED))
			n_items++;
		// bursts with random pauses in between
		if (sender_bursty) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				gap = $urandom_range(1, 6);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(0, 12);
			end
		end
	endtask

	// query near a stored target or anywhere
	task automatic send_query();
		logic signed [COORD_BITS-1:0] qx;
		logic signed [COORD_BITS-1:0] qy;
		int k;
		if (target_count > 0 && $urandom_range(0, 2) == 0) begin
			k = $urandom_range(0, target_count - 1);
			qx = target_x[k] + COORD_BITS'(int'($urandom_range(0, 6)) - 3);
			qy = target_y[k] + COORD_BITS'(int'($urandom_range(0, 6)) - 3);
		end else begin
			qx = rand_coord();
			qy = rand_coord();
		end
		send_item(OP_QUERY, qx, qy);
	endtask

	task automatic test_directed();
		// empty set, unused code ignored
		send_item(OP_QUERY, 0, 0);
		send_item(op_t'(OP_UNUSED), 16'sh7FFF, 16'sh8000);
		send_item(OP_QUERY, 16'sh8000, 16'sh7FFF);
		// corner to corner gives the widest distance
		send_item(OP_LOAD, 16'sh8000, 16'sh8000);
		send_item(OP_QUERY, 16'sh7FFF, 16'sh7FFF);
		send_item(OP_LOAD, 16'sh7FFF, 16'sh7FFF);
		send_item(OP_LOAD, 16'sh8000, 16'sh8000);
		send_item(OP_QUERY, 16'sh8000, 16'sh8000);
		send_item(OP_QUERY, 0, 0);
		send_item(OP_QUERY, 16'sh7FFF, 16'sh8000);
		// clear keeps the entries but empties the set
		send_item(OP_CLEAR, 16'sh7FFF, 16'sh7FFF);
		send_item(OP_QUERY, 0, 0);
		// four-way and two-way ties
		send_item(OP_LOAD, 100, 0);
		send_item(OP_LOAD, -100, 0);
		send_item(OP_LOAD, 0, 100);
		send_item(OP_LOAD, 0, -100);
		send_item(OP_QUERY, 0, 0);
		send_item(op_t'(OP_UNUSED), -1, -1);
		send_item(OP_QUERY, 1, 0);
		send_item(OP_QUERY, -1, -1);
		send_item(OP_LOAD, -1, -1);
		send_item(OP_QUERY, -1, -1);
	endtask

	task automatic test_capacity();
		logic signed [COORD_BITS-1:0] far_x;
		logic signed [COORD_BITS-1:0] far_y;
		send_item(OP_CLEAR, 0, 0);
		for (int i = 0; i < MAX_TGT; i++)
			send_item(OP_LOAD, rand_coord(), rand_coord());
		send_item(OP_QUERY, target_x[MAX_TGT-1], target_y[MAX_TGT-1]);
		send_item(OP_QUERY, target_x[0], target_y[0]);
		// loads into a full set are dropped
		far_x = rand_coord();
		far_y = rand_coord();
		send_item(OP_LOAD, far_x, far_y);
		send_item(OP_LOAD, rand_coord(), rand_coord());
		send_item(OP_QUERY, far_x, far_y);
		send_query();
		send_item(OP_CLEAR, 0, 0);
		send_item(OP_QUERY, far_x, far_y);
	endtask

	// receiver holds off while queries keep coming, so the input stalls
	task automatic test_backpressure();
		bit saved;
		saved = sender_bursty;
		sender_bursty = 1'b0;
		send_item(OP_CLEAR, 0, 0);
		repeat (4) send_item(OP_LOAD, rand_coord(), rand_coord());
		hold_left = 300;
		repeat (6) send_query();
		send_item(OP_LOAD, rand_coord(), rand_coord());
		repeat (2) send_query();
		sender_bursty = saved;
	endtask

	task automatic test_random();
		int  start;
		int  kind;
		int  n;
		int  r;
		op_t op;
		start = n_items;
		while (n_items - start < 580) begin
			if ($urandom_range(0, 7) == 0)
				sender_bursty = !sender_bursty;
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				// clear, fill, then a few queries
				send_item(OP_CLEAR, rand_coord(), rand_coord());
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 12);
				repeat (n) send_item(OP_LOAD, rand_coord(), rand_coord());
				repeat ($urandom_range(1, 5)) send_query();
			end else if (kind < 9) begin
				// any mix, unused code included
				repeat ($urandom_range(1, 8)) begin
					r = $urandom_range(0, 3);
					op = op_t'(r[1:0]);
					if (op == OP_LOAD && target_count >= 128)
						op = OP_CLEAR;
					if (op == OP_QUERY)
						send_query();
					else
						send_item(op, rand_coord(), rand_coord());
				end
			end else begin
				// broken sequences: query straight after clear, junk among loads
				send_item(OP_CLEAR, rand_coord(), rand_coord());
				send_query();
				send_item(OP_LOAD, rand_coord(), rand_coord());
				send_item(op_t'(OP_UNUSED), rand_coord(), rand_coord());
				send_item(OP_LOAD, rand_coord(), rand_coord());
				send_item(OP_CLEAR, rand_coord(), rand_coord());
				send_item(OP_CLEAR, rand_coord(), rand_coord());
				send_query();
			end
		end
	endtask

	// receiver: pattern changes segment by segment, long hold on request
	initial begin : receiver
		int mode;
		int seg;
		int phase;
		mode = 0;
		seg = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				if (seg == 0) begin
					mode = $urandom_range(0, 3);
					seg = $urandom_range(20, 200);
				end
				seg--;
				phase++;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ((phase % 7) >= 3);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (out_valid && out_ready) begin
			if (expected_matches.size() == 0) begin
				report_mismatch($sformatf("unexpected result index %0d",
					out_data.match_index));
			end else begin
				want = expected_matches.pop_front();
				if (out_data.match_index !== want.match_index)
					report_mismatch($sformatf("match_index got %0d want %0d",
						out_data.match_index, want.match_index));
				if (out_data.found !== want.found)
					report_mismatch($sformatf("found got %0b want %0b",
						out_data.found, want.found));
				if (out_data.dist_sqrd !== want.dist_sqrd)
					report_mismatch($sformatf("dist_sqrd got %0d want %0d",
						out_data.dist_sqrd, want.dist_sqrd));
			end
			n_results++;
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_capacity();
		test_backpressure();
		test_random();
		in_valid <= 1'b0;
		while (expected_matches.size() != 0) @(posedge clk);
		repeat (32) @(posedge clk);
		if (n_errors == 0 && expected_matches.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
